FILE: rtl/core/button_gesture_motor_mode_core_assert.svh
// Assertion macros shared by the button gesture motor mode RTL.
`ifndef BUTTON_GESTURE_MOTOR_MODE_CORE_ASSERT_SVH
`define BUTTON_GESTURE_MOTOR_MODE_CORE_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define BGM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgm assertion failed: same-cycle implication");

// Next-cycle implication under synchronous active-low reset.
`define BGM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgm assertion failed: next-cycle implication");

`endif

FILE: rtl/core/bgm_pkg.sv
// Shared types, codes and reset values for the button gesture motor mode core.
package bgm_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned GEST_W = 2;
  localparam int unsigned IDX_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOTE_ON  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOTE_OFF = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;

  // Motor modes
  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOCK = 2'd2;

  // Gesture codes
  localparam logic [GEST_W-1:0] GEST_NONE   = 2'd0;
  localparam logic [GEST_W-1:0] GEST_SINGLE = 2'd1;
  localparam logic [GEST_W-1:0] GEST_DOUBLE = 2'd2;
  localparam logic [GEST_W-1:0] GEST_HOLD   = 2'd3;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_BOUNCE = 2'd0;
  localparam logic [IDX_W-1:0] REG_HOLD   = 2'd1;
  localparam logic [IDX_W-1:0] REG_DOUBLE = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] BOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_RST   = 16'd250;
  localparam logic [CFG_W-1:0] DOUBLE_RST = 16'd500;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              button_level;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic              prev_level;
    logic [TIME_W-1:0] press_start;
    logic [TIME_W-1:0] last_release;
    logic              hold_active;
    logic              single_pending;
    logic [MODE_W-1:0] mode;
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] motor_mode;
    logic              motor_drive;
    logic [GEST_W-1:0] gesture;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] bounce_ms;
    logic [CFG_W-1:0] hold_ms;
    logic [CFG_W-1:0] double_ms;
  } cfg_t;

endpackage

FILE: rtl/core/bgm_in_reg.sv
// Input request register with valid flag and back-pressure from the compute stage.
module bgm_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bgm_pkg::item_t in_item,
  input  logic          advance,
  output logic          item_vld,
  output bgm_pkg::item_t item
);

  logic           vld_r, vld_nxt;
  bgm_pkg::item_t item_r, item_nxt;

  // Take a new request when empty or when the held one moves on this cycle.
  assign in_ready = !vld_r || advance;

  always_comb begin
    vld_nxt  = vld_r;
    item_nxt = item_r;
    if (in_ready) begin
      vld_nxt = in_valid;
      if (in_valid) begin
        item_nxt = in_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

FILE: rtl/core/bgm_step.sv
// Combinational gesture classification and mode update for one request.
module bgm_step (
  input  bgm_pkg::item_t   item,
  input  bgm_pkg::state_t  cur,
  input  bgm_pkg::cfg_t    cfg,
  output bgm_pkg::state_t  nxt,
  output bgm_pkg::result_t res
);

  logic [bgm_pkg::TIME_W-1:0] press_dt;
  logic [bgm_pkg::TIME_W-1:0] rel_dt;
  logic                       rise, fall, both_high, counted;
  logic [bgm_pkg::GEST_W-1:0] gest;

  assign press_dt  = item.now_ms - cur.press_start;
  assign rel_dt    = item.now_ms - cur.last_release;
  assign rise      = item.button_level && !cur.prev_level;
  assign fall      = !item.button_level && cur.prev_level;
  assign both_high = item.button_level && cur.prev_level;
  assign counted   = fall && (press_dt > {16'd0, cfg.bounce_ms}) && !cur.hold_active;

  always_comb begin
    nxt  = cur;
    gest = bgm_pkg::GEST_NONE;
    unique case (item.command)
      bgm_pkg::CMD_REMOTE_ON:  nxt.mode = bgm_pkg::MODE_ON;
      bgm_pkg::CMD_REMOTE_OFF: nxt.mode = bgm_pkg::MODE_OFF;
      bgm_pkg::CMD_TICK: begin
        if (rise) begin
          nxt.press_start = item.now_ms;
        end
        if (both_high && (press_dt > {16'd0, cfg.hold_ms})) begin
          nxt.mode        = bgm_pkg::MODE_ON;
          nxt.hold_active = 1'b1;
        end
        if (counted) begin
          if (rel_dt >= {16'd0, cfg.double_ms}) begin
            nxt.single_pending = 1'b1;
          end else begin
            nxt.mode = (cur.mode == bgm_pkg::MODE_LOCK) ? bgm_pkg::MODE_OFF
                                                        : bgm_pkg::MODE_LOCK;
            nxt.single_pending = 1'b0;
            gest = bgm_pkg::GEST_DOUBLE;
          end
          nxt.last_release = item.now_ms;
        end
        if (fall && cur.hold_active) begin
          nxt.mode        = bgm_pkg::MODE_OFF;
          nxt.hold_active = 1'b0;
          gest            = bgm_pkg::GEST_HOLD;
        end
        nxt.prev_level = item.button_level;
        // A counted release resets the window, so only an old pending single expires.
        if (cur.single_pending && !counted && (rel_dt > {16'd0, cfg.double_ms})) begin
          nxt.mode = (nxt.mode == bgm_pkg::MODE_OFF) ? bgm_pkg::MODE_ON
                                                     : bgm_pkg::MODE_OFF;
          nxt.single_pending = 1'b0;
          gest = bgm_pkg::GEST_SINGLE;
        end
      end
      bgm_pkg::CMD_UNUSED: ;
      default: ;
    endcase
  end

  assign res.motor_mode  = nxt.mode;
  assign res.motor_drive = (nxt.mode == bgm_pkg::MODE_ON);
  assign res.gesture     = gest;

endmodule

FILE: rtl/core/button_gesture_motor_mode_core.sv
// Top level of the button gesture motor mode core: registers, state and result stage.
//
//  Port group | Handshake          | Payload
//  -----------+--------------------+-------------------------------------------
//  in_        | in_valid/in_ready  | in_command, in_button_level, in_now_ms
//  out_       | out_valid/out_ready| out_motor_mode, out_motor_drive, out_gesture
//  cfg_       | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// One request per cycle sustained while out_ready stays high. A request is
// classified while it sits in the input register; when it advances, the
// button/mode state and the result register update together and out_valid
// rises; the result leaves the result register on out_ready. Back-to-back
// requests see the state left by their predecessor.
// Reset (rst_n low, synchronous) empties both stages, loads the register
// defaults (bounce 50, hold 250, double 500) and clears the state to
// released/off.
// A stalled result holds in the output register; the input register keeps
// accepting until it too is full, and in_ready falls only then.
module button_gesture_motor_mode_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bgm_pkg::CMD_W-1:0]   in_command,
  input  logic                        in_button_level,
  input  logic [bgm_pkg::TIME_W-1:0]  in_now_ms,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bgm_pkg::MODE_W-1:0]  out_motor_mode,
  output logic                        out_motor_drive,
  output logic [bgm_pkg::GEST_W-1:0]  out_gesture,
  // configuration writes
  input  logic                        cfg_we,
  input  logic [bgm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bgm_pkg::CFG_W-1:0]   cfg_wdata
);

  `include "button_gesture_motor_mode_core_assert.svh"

  bgm_pkg::item_t   in_item;
  bgm_pkg::item_t   item;
  logic             item_vld;
  logic             advance;

  bgm_pkg::cfg_t    cfg_r, cfg_nxt;
  bgm_pkg::state_t  state_r, state_nxt, step_state;
  bgm_pkg::result_t step_res;
  bgm_pkg::result_t res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_item.command      = in_command;
  assign in_item.button_level = in_button_level;
  assign in_item.now_ms       = in_now_ms;

  // Move a request into the result register when it is free or being drained.
  assign advance = item_vld && (!out_valid_r || out_ready);

  bgm_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  bgm_step u_step (
    .item (item),
    .cur  (state_r),
    .cfg  (cfg_r),
    .nxt  (step_state),
    .res  (step_res)
  );

  // Configuration: write by index, drop writes to unused indexes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bgm_pkg::REG_BOUNCE: cfg_nxt.bounce_ms = cfg_wdata;
        bgm_pkg::REG_HOLD:   cfg_nxt.hold_ms   = cfg_wdata;
        bgm_pkg::REG_DOUBLE: cfg_nxt.double_ms = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Commit state and result only when the request advances.
  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (advance) begin
      state_nxt     = step_state;
      res_nxt       = step_res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bounce_ms      <= bgm_pkg::BOUNCE_RST;
      cfg_r.hold_ms        <= bgm_pkg::HOLD_RST;
      cfg_r.double_ms      <= bgm_pkg::DOUBLE_RST;
      state_r.prev_level     <= 1'b0;
      state_r.press_start    <= '0;
      state_r.last_release   <= '0;
      state_r.hold_active    <= 1'b0;
      state_r.single_pending <= 1'b0;
      state_r.mode           <= bgm_pkg::MODE_OFF;
      out_valid_r          <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_motor_mode  = res_r.motor_mode;
  assign out_motor_drive = res_r.motor_drive;
  assign out_gesture     = res_r.gesture;

  // Drive follows the reported mode.
  `BGM_ASSERT_IMPL(a_drive_mode, clk, rst_n, out_valid_r,
                   out_motor_drive == (out_motor_mode == bgm_pkg::MODE_ON))
  // A released hold leaves the motor off.
  `BGM_ASSERT_IMPL(a_hold_off, clk, rst_n,
                   out_valid_r && (out_gesture == bgm_pkg::GEST_HOLD),
                   out_motor_mode == bgm_pkg::MODE_OFF)
  // A double press ends in off or locked.
  `BGM_ASSERT_IMPL(a_double_mode, clk, rst_n,
                   out_valid_r && (out_gesture == bgm_pkg::GEST_DOUBLE),
                   (out_motor_mode == bgm_pkg::MODE_OFF) ||
                   (out_motor_mode == bgm_pkg::MODE_LOCK))
  // An advancing request always lands in the result register.
  `BGM_ASSERT_NEXT(a_advance_lands, clk, rst_n, advance, out_valid_r)

endmodule
